// File: sv/amqpd_pkg.sv
`timescale 1ns / 1ps

package amqpd_pkg;

  localparam int unsigned HDR_BYTES   = 8;
  localparam int unsigned WORD_BYTES  = 4;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_SIZE       = 2'd1;
  localparam logic [1:0] ERR_OFFSET     = 2'd2;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] frame_size;
    logic [7:0]  frame_type;
    logic [15:0] channel_number;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
    logic [1:0]  error_code;
    logic        last;
  } result_t;

endpackage

// File: sv/amqpd_front.sv
`timescale 1ns / 1ps

module amqpd_front
  import amqpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  input  logic        take,
  input  logic [7:0]  data_byte,
  output logic        res_valid,
  output result_t     res
);

  logic [31:0] max_size;
  logic [31:0] pos;
  logic [31:0] pos_next;
  logic [31:0] size;
  logic [31:0] size_next;
  logic [31:0] size_m1;
  logic [31:0] size_m1_next;
  logic [9:0]  offset;
  logic [9:0]  offset_next;
  logic [7:0]  ftype;
  logic [7:0]  ftype_next;
  logic [15:0] chan;
  logic [15:0] chan_next;
  logic        err;
  logic        err_next;

  logic        in_hdr;
  logic [31:0] offset_w;
  logic        size_over;
  logic        off_bad;
  logic [31:0] plen;

  assign in_hdr    = (pos < 32'(HDR_BYTES));
  assign offset_w  = {22'd0, offset};
  assign size_over = (max_size != 32'd0) && (size > max_size);
  assign off_bad   = (offset < 10'(HDR_BYTES)) || (offset_w > size);
  assign plen      = size - offset_w;

  always_comb begin
    pos_next     = pos;
    size_next    = size;
    size_m1_next = size_m1;
    offset_next  = offset;
    ftype_next   = ftype;
    chan_next    = chan;
    err_next     = err;
    res_valid    = 1'b0;
    res.kind           = KIND_HEADER;
    res.frame_size     = size;
    res.frame_type     = ftype;
    res.channel_number = chan;
    res.payload_length = 32'd0;
    res.payload_byte   = 8'd0;
    res.error_code     = ERR_NONE;
    res.last           = 1'b0;
    if (take && !err) begin
      if (in_hdr) begin
        pos_next = pos + 32'd1;
        case (pos[2:0])
          3'd0: size_next = {data_byte, 24'd0};
          3'd1, 3'd2, 3'd3: size_next = {size[23:0], data_byte};
          3'd4: offset_next = {data_byte, 2'b00};
          3'd5: ftype_next = data_byte;
          3'd6: chan_next = {data_byte, 8'd0};
          3'd7: chan_next = {chan[15:8], data_byte};
          default: pos_next = pos;
        endcase
        if (pos[2:0] == 3'd7) begin
          // header complete: checks run on the captured size and offset
          res_valid          = 1'b1;
          res.channel_number = {chan[15:8], data_byte};
          size_m1_next       = size - 32'd1;
          if (size_over) begin
            err_next       = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_SIZE;
          end else if (off_bad) begin
            err_next       = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_OFFSET;
          end else if (plen == 32'd0) begin
            pos_next = 32'd0;
            res.last = 1'b1;
          end else begin
            res.payload_length = plen;
          end
        end
      end else if (pos < offset_w) begin
        pos_next = pos + 32'd1;
      end else begin
        res_valid        = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = data_byte;
        if (pos >= size_m1) begin
          pos_next = 32'd0;
          res.last = 1'b1;
        end else begin
          pos_next = pos + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_size <= 32'd0;
      pos      <= 32'd0;
      err      <= 1'b0;
      size     <= 32'd0;
      size_m1  <= 32'd0;
      offset   <= 10'd0;
      ftype    <= 8'd0;
      chan     <= 16'd0;
    end else begin
      if (cfg_write) begin
        max_size <= cfg_data;
      end
      pos     <= pos_next;
      err     <= err_next;
      size    <= size_next;
      size_m1 <= size_m1_next;
      offset  <= offset_next;
      ftype   <= ftype_next;
      chan    <= chan_next;
    end
  end

endmodule

// File: sv/amqpd_queue.sv
`timescale 1ns / 1ps

module amqpd_queue
  import amqpd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  result_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                pop;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/amqp_frame_deframer.sv
`timescale 1ns / 1ps
// Byte-stream deframer for AMQP 1.0 frames.
// Input channel: one stream byte per transfer on data_byte (in_valid/in_stall).
// Output channel: one result per transfer (out_valid/out_stall): a header
// result after the eighth header byte, one result per payload byte with last
// on the frame's final byte, or a single error result. Extended header bytes
// and every byte after an error give no result.
// cfg_write/cfg_data set the maximum frame size (zero means no limit); write
// it only while no transfer is in flight.
// Throughput: one byte per cycle while in_stall is low; the parser's position
// counter handles each byte as it is taken. A result is written into a 4-entry
// queue when its byte is taken and is shown on the output once it is the head.
// When the receiver stalls, results collect in the queue; in_stall rises once
// the queue is full and falls as soon as an entry leaves.
// Reset (rst, synchronous) clears the queue, the error latch, the position
// counter and the size limit; the next byte is taken as a frame start.

module amqp_frame_deframer
  import amqpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [31:0] frame_size,
  output logic [7:0]  frame_type,
  output logic [15:0] channel_number,
  output logic [31:0] payload_length,
  output logic [7:0]  payload_byte,
  output logic [1:0]  error_code,
  output logic        last
);

  logic    full;
  logic    take;
  logic    res_valid;
  result_t res;
  result_t head;

  assign in_stall = full;
  assign take     = in_valid && !full;

  amqpd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .take      (take),
    .data_byte (data_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  amqpd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (head)
  );

  assign kind           = head.kind;
  assign frame_size     = head.frame_size;
  assign frame_type     = head.frame_type;
  assign channel_number = head.channel_number;
  assign payload_length = head.payload_length;
  assign payload_byte   = head.payload_byte;
  assign error_code     = head.error_code;
  assign last           = head.last;

endmodule

// File: sv/amqpd_checker.sv
`timescale 1ns / 1ps

module amqpd_checker
  import amqpd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  kind,
  input logic [31:0] payload_length,
  input logic [7:0]  payload_byte,
  input logic [1:0]  error_code,
  input logic        last
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(payload_byte)
      && $stable(last))
    else $error("stalled result changed");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == KIND_HEADER || kind == KIND_PAYLOAD || kind == KIND_ERROR))
    else $error("undefined result kind");

  a_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ERROR |-> error_code != ERR_NONE && !last
      && payload_length == 32'd0)
    else $error("malformed error result");

  a_noerr: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_ERROR |-> error_code == ERR_NONE)
    else $error("error code on a non-error result");

  a_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_PAYLOAD |-> payload_length == 32'd0)
    else $error("payload length on a payload result");

endmodule

bind amqp_frame_deframer amqpd_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .kind           (kind),
  .payload_length (payload_length),
  .payload_byte   (payload_byte),
  .error_code     (error_code),
  .last           (last)
);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import amqpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 800000;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned HOLD_CYCLES = 300;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  kind;
  logic [31:0] frame_size;
  logic [7:0]  frame_type;
  logic [15:0] channel_number;
  logic [31:0] payload_length;
  logic [7:0]  payload_byte;
  logic [1:0]  error_code;
  logic        last;

  amqp_frame_deframer dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .frame_size     (frame_size),
    .frame_type     (frame_type),
    .channel_number (channel_number),
    .payload_length (payload_length),
    .payload_byte   (payload_byte),
    .error_code     (error_code),
    .last           (last)
  );

  // expected results, oldest first
  result_t pending_results[$];
  int unsigned mismatches = 0;
  int unsigned sent_items = 0;
  int unsigned cycles = 0;
  bit src_idles = 1'b0;
  bit sink_idles = 1'b0;
  bit sink_hold_req = 1'b0;

  // deframer state as the predictor sees it
  logic [31:0] at_byte     = '0;
  logic [31:0] cap_size    = '0;
  logic [9:0]  cap_offset  = '0;
  logic [7:0]  cap_type    = '0;
  logic [15:0] cap_chan    = '0;
  bit          stream_dead = 1'b0;
  logic [31:0] size_limit  = '0;

  // directed stream: empty frame with all-ones type/channel, then a frame
  // with a one-word extended header and two payload bytes
  logic [7:0] dir_bytes [0:21] = '{
    8'h00, 8'h00, 8'h00, 8'h08, 8'h02, 8'hFF, 8'hFF, 8'hFF,
    8'h00, 8'h00, 8'h00, 8'h0E, 8'h03, 8'h00, 8'h00, 8'h00,
    8'hA5, 8'h5A, 8'h00, 8'hFF,
    8'h00, 8'hFF
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic result_t mk(kind_t k, logic [31:0] sz, logic [7:0] ty, logic [15:0] ch,
                                 logic [31:0] pl, logic [7:0] pb, logic [1:0] ec, logic la);
    result_t r;
    r.kind = k;
    r.frame_size = sz;
    r.frame_type = ty;
    r.channel_number = ch;
    r.payload_length = pl;
    r.payload_byte = pb;
    r.error_code = ec;
    r.last = la;
    return r;
  endfunction

  task automatic dir_expect(input int row, output bit typed, output result_t r);
    typed = 1'b1;
    case (row)
      7:       r = mk(KIND_HEADER, 32'd8, 8'hFF, 16'hFFFF, 32'd0, 8'h00, ERR_NONE, 1'b1);
      15:      r = mk(KIND_HEADER, 32'd14, 8'h00, 16'h0000, 32'd2, 8'h00, ERR_NONE, 1'b0);
      20:      r = mk(KIND_PAYLOAD, 32'd14, 8'h00, 16'h0000, 32'd0, 8'h00, ERR_NONE, 1'b0);
      21:      r = mk(KIND_PAYLOAD, 32'd14, 8'h00, 16'h0000, 32'd0, 8'hFF, ERR_NONE, 1'b1);
      default: begin
        typed = 1'b0;
        r = '0;
      end
    endcase
  endtask

  task automatic deframe_byte(input logic [7:0] b, output bit got, output result_t r);
    logic [31:0] plen;
    got = 1'b0;
    r = '0;
    if (stream_dead) return;
    if (at_byte < HDR_BYTES) begin
      case (at_byte[2:0])
        3'd0:             cap_size = {b, 24'd0};
        3'd1, 3'd2, 3'd3: cap_size = {cap_size[23:0], b};
        3'd4:             cap_offset = 10'(WORD_BYTES * b);
        3'd5:             cap_type = b;
        3'd6:             cap_chan = {b, 8'd0};
        default:          cap_chan[7:0] = b;
      endcase
    end
    r.frame_size = cap_size;
    r.frame_type = cap_type;
    r.channel_number = cap_chan;
    if (at_byte < HDR_BYTES) begin
      if (at_byte < HDR_BYTES - 1) begin
        at_byte++;
        return;
      end
      got = 1'b1;
      // size check first, offset only if the size passes
      if (size_limit != 0 && cap_size > size_limit) begin
        stream_dead = 1'b1;
        r.kind = KIND_ERROR;
        r.error_code = ERR_SIZE;
      end else if (cap_offset < HDR_BYTES || 32'(cap_offset) > cap_size) begin
        stream_dead = 1'b1;
        r.kind = KIND_ERROR;
        r.error_code = ERR_OFFSET;
      end else begin
        plen = cap_size - 32'(cap_offset);
        r.kind = KIND_HEADER;
        r.payload_length = plen;
        r.last = (plen == 0);
        at_byte = (plen == 0) ? 32'd0 : 32'(HDR_BYTES);
      end
    end else if (at_byte < 32'(cap_offset)) begin
      at_byte++;
    end else begin
      got = 1'b1;
      r.kind = KIND_PAYLOAD;
      r.payload_byte = b;
      if (at_byte >= cap_size - 32'd1) begin
        r.last = 1'b1;
        at_byte = '0;
      end else begin
        at_byte++;
      end
    end
  endtask

  // one byte transfer on the input side, then predict
  task automatic push_byte(input logic [7:0] b, input bit typed, input result_t want);
    int unsigned gap;
    bit got;
    result_t r;
    gap = src_idles ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    deframe_byte(b, got, r);
    if (typed) pending_results.push_back(want);
    else if (got) pending_results.push_back(r);
  endtask

  task automatic send_header(input logic [31:0] sz, input logic [7:0] off_words,
                             input logic [7:0] ty, input logic [15:0] ch);
    push_byte(sz[31:24], 1'b0, '0);
    push_byte(sz[23:16], 1'b0, '0);
    push_byte(sz[15:8], 1'b0, '0);
    push_byte(sz[7:0], 1'b0, '0);
    push_byte(off_words, 1'b0, '0);
    push_byte(ty, 1'b0, '0);
    push_byte(ch[15:8], 1'b0, '0);
    push_byte(ch[7:0], 1'b0, '0);
  endtask

  task automatic send_frame(input int unsigned words, input int unsigned plen);
    send_header(32'(4 * words + plen), 8'(words), 8'($urandom_range(0, 255)),
                16'($urandom_range(0, 65535)));
    repeat (4 * words - HDR_BYTES) push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
    repeat (plen) push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
    sent_items += 4 * words + plen;
  endtask

  // stop sending and let every expected result come out
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] v);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    size_limit = v;
  endtask

  task automatic run_phase(input logic [31:0] lim, input int unsigned budget, input bit hold,
                           input bit big);
    int unsigned start;
    int unsigned words;
    longint plen;
    drain();
    write_limit(lim);
    src_idles = ($urandom_range(0, 3) != 0);
    sink_idles = ($urandom_range(0, 3) != 0);
    if (hold) begin
      src_idles = 1'b0;
      sink_hold_req = 1'b1;
    end
    // a long skipped extended header
    if (big) send_frame(40, $urandom_range(0, 5));
    start = sent_items;
    while (sent_items - start < budget) begin
      words = $urandom_range(2, 5);
      if (lim != 0 && longint'(4 * words) > longint'(lim)) words = 2;
      plen = (hold || $urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12);
      if (lim != 0 && longint'(4 * words) + plen > longint'(lim))
        plen = longint'(lim) - 4 * words;
      // frame exactly at the limit
      if (lim != 0 && lim <= 64 && $urandom_range(0, 3) == 0)
        plen = longint'(lim) - 4 * words;
      send_frame(words, int'(plen));
    end
  endtask

  initial begin : sink
    int unsigned stall_left;
    result_t seen;
    result_t want;
    bit bad;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && !out_stall) begin
        seen = mk(kind_t'(kind), frame_size, frame_type, channel_number, payload_length,
                  payload_byte, error_code, last);
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: kind %0d size %h type %h chan %h plen %h byte %h err %0d last %b",
                     seen.kind, seen.frame_size, seen.frame_type, seen.channel_number,
                     seen.payload_length, seen.payload_byte, seen.error_code, seen.last);
        end else begin
          want = pending_results.pop_front();
          bad = (seen.kind !== want.kind) || (seen.frame_size !== want.frame_size) ||
                (seen.frame_type !== want.frame_type) ||
                (seen.channel_number !== want.channel_number) ||
                (seen.payload_length !== want.payload_length) ||
                (seen.payload_byte !== want.payload_byte) ||
                (seen.error_code !== want.error_code) || (seen.last !== want.last);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch exp: kind %0d size %h type %h chan %h plen %h byte %h err %0d last %b",
                       want.kind, want.frame_size, want.frame_type, want.channel_number,
                       want.payload_length, want.payload_byte, want.error_code, want.last);
              $display("         got: kind %0d size %h type %h chan %h plen %h byte %h err %0d last %b",
                       seen.kind, seen.frame_size, seen.frame_type, seen.channel_number,
                       seen.payload_length, seen.payload_byte, seen.error_code, seen.last);
            end
          end
        end
        stall_left = sink_idles ? $urandom_range(0, 15) : 0;
      end
      // long hold-off so the output queue fills and the input stalls
      if (sink_hold_req) begin
        stall_left = HOLD_CYCLES;
        sink_hold_req = 1'b0;
      end
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  initial begin : stimulus
    bit typed;
    result_t want;
    logic [31:0] lim;
    logic [31:0] esize;
    logic [7:0] eoff;
    int unsigned choice;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    data_byte <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    write_limit(32'd0);
    src_idles = 1'b1;
    sink_idles = 1'b1;
    for (int i = 0; i < 22; i++) begin
      dir_expect(i, typed, want);
      push_byte(dir_bytes[i], typed, want);
    end

    run_phase(32'hFFFF_FFFF, 45, 1'b0, 1'b0);
    run_phase(32'd0, 55, 1'b1, 1'b0);
    run_phase(32'd20, 45, 1'b0, 1'b0);
    run_phase(32'd8, 35, 1'b0, 1'b0);
    run_phase(32'($urandom_range(9, 64)), 45, 1'b0, 1'b0);
    run_phase(32'h8000_0000 | 32'($urandom), 35, 1'b0, 1'b0);
    run_phase(32'd0, 15, 1'b0, 1'b1);

    // a bad header latches the error; the stream is dead from here on
    drain();
    lim = 32'($urandom_range(9, 200));
    write_limit(lim);
    src_idles = 1'b1;
    sink_idles = 1'b1;
    choice = $urandom_range(0, 2);
    esize = 32'($urandom_range(8, lim));
    eoff = 8'($urandom_range(0, 255));
    if (choice == 0) esize = 32'($urandom) | 32'h8000_0000;
    else if (choice == 1) eoff = 8'($urandom_range(0, 1));
    else eoff = 8'($urandom_range(esize / 4 + 1, 255));
    send_header(esize, eoff, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
    repeat (16) push_byte(8'($urandom_range(0, 255)), 1'b0, '0);

    drain();
    if (mismatches == 0 && pending_results.size() == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
